@@ hw/rtl/tlbp_pkg.sv @@
// Shared types and constants for the two-level local branch predictor.
// No dependencies; the predictor and the testbench import this package.

package tlbp_pkg;

    localparam int HISTORY_TABLE_INDEX_BITS_DEF = 10;
    localparam int PATTERN_HISTORY_BITS_DEF     = 8;

    localparam int ADDR_WIDTH = 32;
    // The two lowest address bits are dropped before indexing.
    localparam int ADDR_SHIFT = 2;

    // Two-bit saturating counter codes.
    localparam logic [1:0] CTR_MIN         = 2'd0;
    localparam logic [1:0] CTR_WEAK_TAKEN  = 2'd2;
    localparam logic [1:0] CTR_MAX         = 2'd3;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] branch_address;
        logic                  taken;
    } tlbp_in_t;

    typedef struct packed {
        logic predicted_taken;
        logic mispredicted;
    } tlbp_out_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HIST,
        ST_CTR
    } tlbp_state_t;

endpackage

@@ hw/rtl/tlbp_ram.sv @@
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.

module tlbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/two_level_local_branch_predictor.sv @@
// Two-level local-history branch predictor: one beat in, one result beat out.
// Each beat runs through the history read (ST_HIST) and the counter read (ST_CTR), where
// it waits while the output stalls; no new beat is taken until its result is registered.
// Reset: aresetn (synchronous, active low) starts a clearing pass over all 2^max(H,P)
// addresses (1024 at the defaults) that zeroes the history RAM and sets every counter to
// weakly taken; s_ready stays low until the pass is done.

module two_level_local_branch_predictor
    import tlbp_pkg::*;
#(
    parameter int HISTORY_TABLE_INDEX_BITS = HISTORY_TABLE_INDEX_BITS_DEF,
    parameter int PATTERN_HISTORY_BITS     = PATTERN_HISTORY_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  tlbp_in_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output tlbp_out_t m_payload
);

    localparam int H  = HISTORY_TABLE_INDEX_BITS;
    localparam int P  = PATTERN_HISTORY_BITS;
    localparam int CW = (H > P) ? H : P;
    localparam int HIST_DEPTH = 1 << H;
    localparam int CTR_DEPTH  = 1 << P;

    // Control state.
    tlbp_state_t    state_reg, state_next;
    logic [CW-1:0]  clr_reg, clr_next;
    logic           m_valid_reg, m_valid_next;

    // Item and result payload registers.
    logic [H-1:0]   hidx_reg, hidx_next;
    logic           taken_reg, taken_next;
    tlbp_out_t      m_payload_reg, m_payload_next;

    // RAM ports.
    logic           hist_we, hist_re;
    logic [H-1:0]   hist_addr;
    logic [P-1:0]   hist_wdata, hist_rdata;
    logic           ctr_we, ctr_re;
    logic [P-1:0]   ctr_addr;
    logic [1:0]     ctr_wdata, ctr_rdata;

    logic [P-1:0]   hist_shifted;
    logic [1:0]     ctr_updated;
    logic           pred;
    logic           out_free;

    tlbp_ram #(
        .WIDTH (P),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .re    (hist_re),
        .addr  (hist_addr),
        .wdata (hist_wdata),
        .rdata (hist_rdata)
    );

    tlbp_ram #(
        .WIDTH (2),
        .DEPTH (CTR_DEPTH)
    ) u_ctr_ram (
        .aclk  (aclk),
        .we    (ctr_we),
        .re    (ctr_re),
        .addr  (ctr_addr),
        .wdata (ctr_wdata),
        .rdata (ctr_rdata)
    );

    // The new history moves one place toward the low end, and the outcome enters at the top.
    generate
        if (P > 1) begin : g_shift
            assign hist_shifted = {taken_reg, hist_rdata[P-1:1]};
        end else begin : g_single
            assign hist_shifted = taken_reg;
        end
    endgenerate

    // The counter's upper bit is the prediction; the update saturates at both ends.
    assign pred = ctr_rdata[1];

    always_comb begin
        if (taken_reg) begin
            ctr_updated = (ctr_rdata == CTR_MAX) ? CTR_MAX : ctr_rdata + 2'd1;
        end else begin
            ctr_updated = (ctr_rdata == CTR_MIN) ? CTR_MIN : ctr_rdata - 2'd1;
        end
    end

    // The output register can take a new result when it is empty or being drained.
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hidx_reg      <= hidx_next;
        taken_reg     <= taken_next;
        m_payload_reg <= m_payload_next;
    end

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        hidx_next      = hidx_reg;
        taken_next     = taken_reg;
        m_payload_next = m_payload_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        s_ready        = 1'b0;

        hist_we    = 1'b0;
        hist_re    = 1'b0;
        hist_addr  = hidx_reg;
        hist_wdata = hist_shifted;
        ctr_we     = 1'b0;
        ctr_re     = 1'b0;
        ctr_addr   = hist_rdata;
        ctr_wdata  = ctr_updated;

        unique case (state_reg)
            ST_CLEAR: begin
                // One entry of each RAM per cycle; the smaller RAM is simply rewritten.
                hist_we    = 1'b1;
                hist_addr  = clr_reg[H-1:0];
                hist_wdata = '0;
                ctr_we     = 1'b1;
                ctr_addr   = clr_reg[P-1:0];
                ctr_wdata  = CTR_WEAK_TAKEN;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == {CW{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready   = 1'b1;
                hist_addr = s_payload.branch_address[ADDR_SHIFT +: H];
                if (s_valid) begin
                    hist_re    = 1'b1;
                    hidx_next  = s_payload.branch_address[ADDR_SHIFT +: H];
                    taken_next = s_payload.taken;
                    state_next = ST_HIST;
                end
            end
            ST_HIST: begin
                // History word is on the read port: fetch its counter and write the
                // shifted history back in the same cycle.
                ctr_re     = 1'b1;
                hist_we    = 1'b1;
                state_next = ST_CTR;
            end
            ST_CTR: begin
                // The counter read data holds until the next read, so a stalled
                // output just keeps the item here.
                if (out_free) begin
                    ctr_we   = 1'b1;
                    // The counter address must be the index that was read; hist_rdata
                    // still holds the pre-update history since no new history read
                    // has been issued.
                    m_valid_next                   = 1'b1;
                    m_payload_next.predicted_taken = pred;
                    m_payload_next.mispredicted    = pred ^ taken_reg;
                    state_next                     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef SYNTHESIS
    // An accepted beat always moves on to the history read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_HIST))
        else $error("accepted beat did not start a history read");

    // The counter stage follows the history stage and nothing else.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CTR && !$past(state_reg == ST_CTR)) |-> $past(state_reg == ST_HIST))
        else $error("counter stage entered without a history read");

    // A result beat only appears out of the counter stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_CTR))
        else $error("result beat appeared outside the counter stage");

    // No input beat is taken while the clearing pass runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("input accepted during the clearing pass");

    // A waiting result beat is never overwritten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_payload_reg))
        else $error("stalled result beat changed");
`endif

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the two-level local branch predictor.
// Drives branch beats through valid/ready, predicts each result in place and
// compares field by field. Depends on tlbp_pkg and two_level_local_branch_predictor.

module tb;
    import tlbp_pkg::*;

    localparam int HIDX_BITS    = HISTORY_TABLE_INDEX_BITS_DEF;
    localparam int PHIST_BITS   = PATTERN_HISTORY_BITS_DEF;
    localparam int POOL_SIZE    = 12;
    localparam int PHASE_ITEMS  = 185;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 8;

    // One row of the directed table. When typed is set, the result is the
    // one written in the row; otherwise the predictor decides it.
    typedef struct {
        logic [ADDR_WIDTH-1:0] addr;
        logic                  taken;
        bit                    typed;
        logic                  pred;
        logic                  misp;
    } branch_vec_t;

    localparam int N_VEC = 21;

    branch_vec_t directed_branches [N_VEC] = '{
        // Fresh after reset: counter is weakly taken, so taken is predicted.
        '{32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b0},
        // Index 0x3ff still has zero history and lands on the counter that
        // the first row pushed to strongly taken, so not taken is a miss.
        '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1},
        '{32'hFFFF_FFFC, 1'b0, 1'b0, 1'b0, 1'b0},
        // Repeated not taken with zero history walks counter 0 to its floor.
        '{32'h0000_0004, 1'b0, 1'b0, 1'b0, 1'b0},
        '{32'h0000_0004, 1'b0, 1'b0, 1'b0, 1'b0},
        '{32'h0000_0004, 1'b0, 1'b0, 1'b0, 1'b0},
        // A long taken run fills the history with ones and pins its counter high.
        '{32'h0000_0008, 1'b1, 1'b0, 1'b0, 1'b0},
        '{32'h0000_0008, 1'b1, 1'b0, 1'b0, 1'b0},
        '{32'h0000_0008, 1'b1, 1'b0, 1'b0, 1'b0},
        '{32'h0000_0008, 1'b1, 1'b0, 1'b0, 1'b0},
        '{32'h0000_0008, 1'b1, 1'b0, 1'b0, 1'b0},
        '{32'h0000_0008, 1'b1, 1'b0, 1'b0, 1'b0},
        '{32'h0000_0008, 1'b1, 1'b0, 1'b0, 1'b0},
        '{32'h0000_0008, 1'b1, 1'b0, 1'b0, 1'b0},
        '{32'h0000_0009, 1'b1, 1'b0, 1'b0, 1'b0},
        '{32'h0000_000B, 1'b1, 1'b0, 1'b0, 1'b0},
        // The next three differ from address 0 only in high or low two bits and alias onto history register 0.
        '{32'h0000_1000, 1'b0, 1'b0, 1'b0, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0},
        '{32'h0000_0003, 1'b1, 1'b0, 1'b0, 1'b0},
        '{32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, 1'b0},
        '{32'h5555_5555, 1'b0, 1'b0, 1'b0, 1'b0}
    };

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    tlbp_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    tlbp_out_t m_payload;

    two_level_local_branch_predictor uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Predictor state: per-branch local histories and the shared counters.
    logic [PHIST_BITS-1:0] local_history [2**HIDX_BITS];
    logic [1:0]            pattern_ctr   [2**PHIST_BITS];

    tlbp_out_t pending_outcomes [$];
    tlbp_out_t oldest_outcome;
    int        mismatch_count = 0;
    int        idle_cycles    = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;

    // Pool of recurring branches for the random part. Each one repeats a
    // short outcome pattern, which is what a local history can learn.
    logic [ADDR_WIDTH-1:0] pool_addr    [POOL_SIZE];
    logic [15:0]           pool_pattern [POOL_SIZE];
    int                    pool_len     [POOL_SIZE];
    int                    pool_pos     [POOL_SIZE];

    function automatic tlbp_out_t predict_branch(input tlbp_in_t b);
        logic [HIDX_BITS-1:0]  hidx;
        logic [PHIST_BITS-1:0] hist;
        logic [1:0]            ctr;
        tlbp_out_t             res;
        hidx = b.branch_address[ADDR_SHIFT +: HIDX_BITS];
        hist = local_history[hidx];
        ctr  = pattern_ctr[hist];
        res.predicted_taken = (ctr >= CTR_WEAK_TAKEN);
        res.mispredicted    = (res.predicted_taken != b.taken);
        if (b.taken) begin
            if (ctr != CTR_MAX) ctr = ctr + 2'd1;
        end else begin
            if (ctr != CTR_MIN) ctr = ctr - 2'd1;
        end
        pattern_ctr[hist]   = ctr;
        local_history[hidx] = {b.taken, hist[PHIST_BITS-1:1]};
        return res;
    endfunction

    // Entered and left just after a falling edge. Holds the beat until it
    // is accepted, then records what the block should answer.
    task automatic send_branch(input tlbp_in_t b, input bit typed, input tlbp_out_t typed_res);
        tlbp_out_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= b;
        do @(posedge aclk); while (!(s_valid && s_ready));
        res = predict_branch(b);
        pending_outcomes.insert(pending_outcomes.size(), typed ? typed_res : res);
        @(negedge aclk);
    endtask

    task automatic next_random_branch(output tlbp_in_t b);
        int k;
        if ($urandom_range(99) < 20) begin
            b.branch_address = $urandom;
            b.taken          = 1'($urandom_range(1));
        end else begin
            k = $urandom_range(POOL_SIZE - 1);
            b.branch_address = pool_addr[k] ^ $urandom_range(3);
            b.taken          = pool_pattern[k][pool_pos[k]];
            pool_pos[k]      = (pool_pos[k] + 1) % pool_len[k];
            // Occasional noise breaks a learned pattern.
            if ($urandom_range(99) < 6) b.taken = ~b.taken;
        end
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                $error("result beat with no outcome pending");
                mismatch_count++;
            end else begin
                oldest_outcome = pending_outcomes.pop_front();
                if (m_payload.predicted_taken !== oldest_outcome.predicted_taken) begin
                    $error("predicted_taken: expected %0b, got %0b",
                           oldest_outcome.predicted_taken, m_payload.predicted_taken);
                    mismatch_count++;
                end
                if (m_payload.mispredicted !== oldest_outcome.mispredicted) begin
                    $error("mispredicted: expected %0b, got %0b",
                           oldest_outcome.mispredicted, m_payload.mispredicted);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat; covers the clearing pass
    // after reset as well as the longest random gaps.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        tlbp_in_t  b;
        tlbp_out_t typed_res;
        int        ph;
        int        n;

        foreach (local_history[i]) local_history[i] = '0;
        foreach (pattern_ctr[i]) pattern_ctr[i] = CTR_WEAK_TAKEN;

        for (int i = 0; i < POOL_SIZE; i++) begin
            // The second two thirds alias earlier branches by differing only
            // in bits above the history index.
            if (i < 4) pool_addr[i] = $urandom;
            else pool_addr[i] = pool_addr[i - 4] ^ ($urandom << (ADDR_SHIFT + HIDX_BITS));
            pool_pattern[i] = 16'($urandom);
            pool_len[i]     = $urandom_range(16, 1);
            pool_pos[i]     = 0;
        end

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < N_VEC; i++) begin
            b.branch_address          = directed_branches[i].addr;
            b.taken                   = directed_branches[i].taken;
            typed_res.predicted_taken = directed_branches[i].pred;
            typed_res.mispredicted    = directed_branches[i].misp;
            send_branch(b, directed_branches[i].typed, typed_res);
        end

        // Random phases: free running, sender mostly idle, receiver mostly
        // stalling, then both idling lightly.
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                next_random_branch(b);
                send_branch(b, 1'b0, typed_res);
            end
            // Let the pipeline run dry before the next phase starts.
            wait_all_results();
        end

        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
